/* rtl/reduction_aggregation_table_macros.svh */
// Assertion macros for the reduction aggregation table.
// Used by the top level only; no other dependencies.
`ifndef REDUCTION_AGGREGATION_TABLE_MACROS_SVH
`define REDUCTION_AGGREGATION_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RAT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/rat_pkg.sv */
// Package for the reduction aggregation table: payload structs, codes, states.
// No dependencies.
package rat_pkg;
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int REM_W = 17;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_COMBINED = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_FULL     = 3'd3,
        ST_BAD_TYPE = 3'd4,
        ST_BAD_ID   = 3'd5
    } t_status;

    localparam logic [0:0] REG_SELF_ID = 1'd0;

    typedef struct packed {
        logic [31:0]        reduce_key;
        logic [1:0]         message_kind;
        logic [15:0]        source_process;
        logic [15:0]        destination_process;
        logic [15:0]        target_process;
        logic [15:0]        expected_count;
        logic [15:0]        root_count;
        logic signed [31:0] contribution_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        result_id;
        logic [0:0]         result_kind;
        logic [15:0]        result_destination;
        logic [15:0]        result_source;
        logic signed [31:0] result_value;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic update;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic dummy_ready;
    } t_sts;
endpackage

/* rtl/rat_ctrl.sv */
// Controller for the reduction aggregation table: accept, look up, deliver.
// Depends on rat_pkg.
module rat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  rat_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output rat_pkg::t_cmd   o_cmd
);
    rat_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            rat_pkg::S_IDLE: begin
                o_in_ready = i_sts.dummy_ready;
                if (i_in_valid && i_sts.dummy_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = rat_pkg::S_LOOKUP;
                end
            end
            rat_pkg::S_LOOKUP: begin
                o_cmd.update = 1'b1;
                n_state      = rat_pkg::S_OUT;
            end
            rat_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                // take the next word as the result leaves
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = rat_pkg::S_LOOKUP;
                    end else begin
                        n_state = rat_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = rat_pkg::S_IDLE;
        endcase
    end
endmodule

/* rtl/rat_datapath.sv */
// Datapath for the reduction aggregation table: slot store, parallel probe, update.
// Depends on rat_pkg.
module rat_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rat_pkg::t_cmd       i_cmd,
    input  rat_pkg::t_in_word   i_in_word,
    input  logic [15:0]         i_self_id,
    output rat_pkg::t_sts       o_sts,
    output rat_pkg::t_out_word  o_out_word
);
    localparam int N  = rat_pkg::SLOTS;
    localparam int IW = rat_pkg::IDX_W;
    localparam int RW = rat_pkg::REM_W;

    logic [31:0] r_key    [N];
    logic [RW-1:0] r_rem  [N];
    logic [15:0] r_tgt    [N];
    logic        r_kind   [N];
    logic [31:0] r_val    [N];

    rat_pkg::t_in_word  r_in;
    rat_pkg::t_out_word r_out;
    rat_pkg::t_out_word n_out;

    // probe: per-slot hit/empty, then first hit in rotated order from home
    logic [N-1:0] hit_vec;
    logic [IW-1:0] home;
    logic          found;
    logic [IW-1:0] pos;
    logic [IW-1:0] idx;

    always_comb begin
        home  = r_in.reduce_key[IW-1:0];
        found = 1'b0;
        pos   = '0;
        for (int k = 0; k < N; k++) begin
            hit_vec[k] = (r_key[k] == r_in.reduce_key) || (r_key[k] == 32'd0);
        end
        for (int k = N - 1; k >= 0; k--) begin
            idx = home + IW'(k);
            if (hit_vec[idx]) begin
                found = 1'b1;
                pos   = idx;
            end
        end
    end

    logic          is_match;
    logic [RW-1:0] new_rem;
    logic [31:0]   new_val;
    logic [15:0]   new_tgt;
    logic          new_kind;

    always_comb begin
        is_match = (r_key[pos] == r_in.reduce_key);
        if (is_match) begin
            new_rem  = r_rem[pos] + RW'(r_in.expected_count) - RW'(1);
            new_val  = r_val[pos] + r_in.contribution_value;
            new_tgt  = (r_in.source_process == i_self_id) ? r_in.target_process : r_tgt[pos];
            new_kind = r_kind[pos];
        end else begin
            if (r_in.destination_process == 16'd0 && r_in.root_count != 16'd0) begin
                new_rem = RW'(r_in.root_count) - RW'(1);
            end else begin
                new_rem = RW'(r_in.expected_count) - RW'(1);
            end
            new_val  = r_in.contribution_value;
            new_tgt  = r_in.target_process;
            new_kind = r_in.message_kind[0];
        end
    end

    logic bad_type, bad_id, do_write;
    assign bad_type = r_in.message_kind[1];
    assign bad_id   = (r_in.reduce_key == 32'd0);
    assign do_write = i_cmd.update && !bad_type && !bad_id && found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_key[k] <= 32'd0;
        end else if (do_write) begin
            r_key[pos] <= (new_rem == '0) ? 32'd0 : r_in.reduce_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_rem[pos]  <= new_rem;
            r_val[pos]  <= new_val;
            r_tgt[pos]  <= new_tgt;
            r_kind[pos] <= new_kind;
        end
    end

    always_comb begin
        n_out = '0;
        priority if (bad_type) begin
            n_out.status = rat_pkg::ST_BAD_TYPE;
        end else if (bad_id) begin
            n_out.status = rat_pkg::ST_BAD_ID;
        end else if (!found) begin
            n_out.status = rat_pkg::ST_FULL;
        end else if (new_rem == '0) begin
            n_out.status             = rat_pkg::ST_COMPLETE;
            n_out.result_id          = r_in.reduce_key;
            n_out.result_kind        = new_kind;
            n_out.result_destination = new_tgt;
            n_out.result_source      = i_self_id;
            n_out.result_value       = new_val;
        end else if (is_match) begin
            n_out.status = rat_pkg::ST_COMBINED;
        end else begin
            n_out.status = rat_pkg::ST_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.update) begin
            r_out <= n_out;
        end
    end

    assign o_sts.dummy_ready = 1'b1;
    assign o_out_word = r_out;
endmodule

/* rtl/reduction_aggregation_table.sv */
// Reduction aggregation table: combines reduction contributions keyed by id.
// Input and output channels are valid/ready and carry rat_pkg::t_in_word and
// rat_pkg::t_out_word. Each accepted word gives exactly one result word with
// a status: inserted, combined, complete (with the summed value, stored kind,
// stored target as destination and own id as source), table full, bad type
// or bad id.
// The next word is taken in the same cycle the result leaves, and not
// before: one word is in the table at a time. The word is registered at
// accept; the 16-slot key compare, probe priority and slot update all run
// in the next cycle against flip-flop storage, where the result word is
// registered too.
// The receiver may stall: the result is held and no new word is taken until
// it is delivered.
// Reset clears all slot keys (all slots empty) and the own process id at once;
// no clearing pass is needed.
// The APB port holds the own process id at address 0; pready is always high.
`include "reduction_aggregation_table_macros.svh"
module reduction_aggregation_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rat_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rat_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [15:0]   r_self_id;
    rat_pkg::t_cmd cmd;
    rat_pkg::t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= 16'd0;
        end else if (psel && penable && pwrite && paddr[2] == rat_pkg::REG_SELF_ID) begin
            r_self_id <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == rat_pkg::REG_SELF_ID) ? {16'd0, r_self_id} : 32'd0;

    rat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rat_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .i_self_id  (r_self_id),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

    `RAT_ASSERT_NEXT(a_load_then_update, i_clk, i_rst_n, cmd.load, cmd.update)
    `RAT_ASSERT_NEXT(a_update_then_valid, i_clk, i_rst_n, cmd.update, o_out_valid)
    `RAT_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, cmd.update, !o_in_ready && !o_out_valid)
endmodule

/* sim/tb_reduction_aggregation_table.sv */
// Testbench for the reduction aggregation table: directed and random words,
// with an in-bench model of the probing table and APB writes of the self id.
// Depends on rat_pkg and the reduction_aggregation_table top level.
`timescale 1ns / 100ps
module tb_reduction_aggregation_table;
    localparam int STALL_LIMIT = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    rat_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    rat_pkg::t_out_word  o_out_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // model of the table
    logic [31:0] tbl_key [rat_pkg::SLOTS];
    logic [16:0] tbl_rem [rat_pkg::SLOTS];
    logic [15:0] tbl_tgt [rat_pkg::SLOTS];
    logic [15:0] tbl_root [rat_pkg::SLOTS];
    logic        tbl_kind [rat_pkg::SLOTS];
    logic [31:0] tbl_sum [rat_pkg::SLOTS];
    logic [15:0] self_id;

    rat_pkg::t_out_word pending_results [$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;

    reduction_aggregation_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic rat_pkg::t_out_word aggregate(rat_pkg::t_in_word w);
        rat_pkg::t_out_word r;
        int pos;
        bit hit;
        r = '0;
        if (w.message_kind > 2'd1) begin
            r.status = rat_pkg::ST_BAD_TYPE;
            return r;
        end
        if (w.reduce_key == 32'd0) begin
            r.status = rat_pkg::ST_BAD_ID;
            return r;
        end
        pos = int'(w.reduce_key % rat_pkg::SLOTS);
        hit = 1'b0;
        for (int n = 0; n < rat_pkg::SLOTS; n++) begin
            if (!hit) begin
                if (tbl_key[pos] == w.reduce_key || tbl_key[pos] == 32'd0)
                    hit = 1'b1;
                else
                    pos = (pos + 1) % rat_pkg::SLOTS;
            end
        end
        if (!hit) begin
            r.status = rat_pkg::ST_FULL;
            return r;
        end
        if (tbl_key[pos] == w.reduce_key) begin
            tbl_rem[pos] = tbl_rem[pos] + 17'(w.expected_count) - 17'd1;
            if (w.source_process == self_id) begin
                tbl_tgt[pos] = w.target_process;
                tbl_root[pos] = w.root_count;
            end
            tbl_sum[pos] = tbl_sum[pos] + w.contribution_value;
            r.status = rat_pkg::ST_COMBINED;
        end else begin
            tbl_key[pos] = w.reduce_key;
            tbl_kind[pos] = w.message_kind[0];
            tbl_tgt[pos] = w.target_process;
            tbl_root[pos] = w.root_count;
            tbl_sum[pos] = w.contribution_value;
            if (w.destination_process == 16'd0 && w.root_count != 16'd0)
                tbl_rem[pos] = 17'(w.root_count) - 17'd1;
            else
                tbl_rem[pos] = 17'(w.expected_count) - 17'd1;
            r.status = rat_pkg::ST_INSERTED;
        end
        if (tbl_rem[pos] == 17'd0) begin
            tbl_key[pos] = 32'd0;
            r.status = rat_pkg::ST_COMPLETE;
            r.result_id = w.reduce_key;
            r.result_kind = tbl_kind[pos];
            r.result_destination = tbl_tgt[pos];
            r.result_source = self_id;
            r.result_value = tbl_sum[pos];
        end
        return r;
    endfunction

    task automatic send_word(rat_pkg::t_in_word w);
        int gap;
        gap = $urandom_range(0, 4);
        // drop valid only when a gap follows, so valid gets one update per edge
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_results.push_back(aggregate(w));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_self_id(logic [15:0] id);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {rat_pkg::REG_SELF_ID, 2'b00};
        pwdata <= {16'd0, id};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        self_id = id;
    endtask

    function automatic rat_pkg::t_in_word make_word(logic [31:0] id, logic [1:0] kind,
                                                    logic [15:0] src, logic [15:0] dst,
                                                    logic [15:0] expc, logic [15:0] root);
        rat_pkg::t_in_word w;
        w.reduce_key = id;
        w.message_kind = kind;
        w.source_process = src;
        w.destination_process = dst;
        w.target_process = 16'($urandom);
        w.expected_count = expc;
        w.root_count = root;
        w.contribution_value = $urandom;
        return w;
    endfunction

    task automatic test_errors();
        send_word(make_word(32'd5, 2'd2, 16'd1, 16'd1, 16'd2, 16'd0));
        send_word(make_word(32'd0, 2'd3, 16'd1, 16'd1, 16'd2, 16'd0));
        send_word(make_word(32'd0, 2'd0, 16'd1, 16'd1, 16'd2, 16'd0));
    endtask

    task automatic test_combine();
        // insert, own-process combine, then a plain combine
        send_word(make_word(32'hFFFF_FFF3, 2'd1, 16'd9, 16'd4, 16'd3, 16'd7));
        send_word(make_word(32'hFFFF_FFF3, 2'd0, self_id, 16'd4, 16'd1, 16'hFFFF));
        send_word(make_word(32'hFFFF_FFF3, 2'd0, 16'd9, 16'd4, 16'd0, 16'd0));
        // immediate completion and root-count insert
        send_word(make_word(32'd7, 2'd1, 16'd2, 16'd3, 16'd1, 16'd0));
        send_word(make_word(32'd8, 2'd0, 16'd2, 16'd0, 16'd9, 16'd1));
        send_word(make_word(32'd9, 2'd0, 16'd2, 16'd0, 16'd2, 16'd3));
        // count underflow then wrap back to zero
        send_word(make_word(32'd10, 2'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
        send_word(make_word(32'd10, 2'd0, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0));
    endtask

    task automatic test_full_table();
        // fill every slot, one colliding home, then overflow and free
        for (int i = 1; i <= rat_pkg::SLOTS; i++)
            send_word(make_word(32'(i * rat_pkg::SLOTS), 2'd0, 16'd1, 16'd1, 16'd5, 16'd0));
        send_word(make_word(32'h8000_0001, 2'd0, 16'd1, 16'd1, 16'd5, 16'd0));
        // count the home slot down to zero so it frees
        repeat (4)
            send_word(make_word(32'(rat_pkg::SLOTS), 2'd0, 16'd1, 16'd1, 16'd0, 16'd0));
        send_word(make_word(32'h8000_0001, 2'd1, 16'd1, 16'd1, 16'd5, 16'd0));
    endtask

    task automatic test_random(int words);
        rat_pkg::t_in_word w;
        int pick;
        logic [159:0] raw;
        for (int i = 0; i < words; i++) begin
            pick = $urandom_range(0, 99);
            w = make_word(32'($urandom_range(1, 24)), 2'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? self_id : 16'($urandom),
                          ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
                          16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
            if (pick < 5) begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                w = raw[$bits(rat_pkg::t_in_word)-1:0];
            end else if (pick < 10)
                w.reduce_key = $urandom;
            else if (pick < 13)
                w.message_kind = 2'($urandom_range(2, 3));
            else if (pick < 15)
                w.reduce_key = 32'd0;
            else if (pick < 18)
                w.expected_count = 16'($urandom);
            send_word(w);
            if (i == words / 2)
                drain();
        end
    endtask

    // result checker and output stall
    initial begin
        rat_pkg::t_out_word exp_word;
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", o_out_word);
            end else begin
                exp_word = pending_results.pop_front();
                if (o_out_word.status !== exp_word.status
                    || o_out_word.result_id !== exp_word.result_id
                    || o_out_word.result_kind !== exp_word.result_kind
                    || o_out_word.result_destination !== exp_word.result_destination
                    || o_out_word.result_source !== exp_word.result_source
                    || o_out_word.result_value !== exp_word.result_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_word,
                                 o_out_word);
                end
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        timed_out = 1'b0;
        self_id = 16'd0;
        for (int i = 0; i < rat_pkg::SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_rem[i] = '0;
            tbl_tgt[i] = '0;
            tbl_root[i] = '0;
            tbl_kind[i] = '0;
            tbl_sum[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            begin
                test_errors();
                test_combine();
                write_self_id(16'hFFFF);
                test_full_table();
                write_self_id(16'h00A5);
                test_random(350);
                write_self_id(16'h0000);
                test_random(350);
                write_self_id(16'($urandom));
                test_random(350);
                drain();
            end
            wait (timed_out);
        join_any
        if (timed_out) begin
            $display("tb_reduction_aggregation_table: FAIL");
            $finish;
        end else begin
            if (mismatches == 0 && pending_results.size() == 0)
                $display("tb_reduction_aggregation_table: PASS");
            else
                $display("tb_reduction_aggregation_table: FAIL");
            $finish;
        end
    end
endmodule
